>>> hw/rtl/afpt_pkg.sv
package afpt_pkg;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        VERDICT_INSIDE   = 2'd0,
        VERDICT_STRADDLE = 2'd1,
        VERDICT_OUTSIDE  = 2'd2
    } verdict_t;

    localparam int NORMAL_W = 16;
    localparam int FIELD_W  = 32;
    localparam int SLOT_W   = 3;
    localparam int MASK_W   = 8;
    localparam int ACTIVE_W = 4;
    localparam int ACTIVE_RESET = 8;
    localparam int DIST_SHIFT = 14;

    // input tdata layout
    localparam int IN_SLOT_LSB = 0;
    localparam int IN_NX_LSB   = IN_SLOT_LSB + SLOT_W;
    localparam int IN_NY_LSB   = IN_NX_LSB + NORMAL_W;
    localparam int IN_NZ_LSB   = IN_NY_LSB + NORMAL_W;
    localparam int IN_D_LSB    = IN_NZ_LSB + NORMAL_W;
    localparam int IN_MIN_LSB  = IN_D_LSB + FIELD_W;
    localparam int IN_MAX_LSB  = IN_MIN_LSB + 3 * FIELD_W;
    localparam int IN_USED_W   = IN_MAX_LSB + 3 * FIELD_W;
    localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_VERDICT_LSB = 0;
    localparam int OUT_OUTSIDE_LSB = 2;
    localparam int OUT_STRADDLE_LSB = OUT_OUTSIDE_LSB + MASK_W;
    localparam int OUT_USED_W  = OUT_STRADDLE_LSB + MASK_W;
    localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

endpackage

>>> hw/rtl/aabb_frustum_plane_test_core.sv
// Box versus plane-set classifier. A load item (tuser = 0) writes one plane into the
// table and gives no result; it is seen by every item accepted after it. A test item
// (tuser = 1) gives one result through 4 pipeline stages (input capture, corner pick
// and multiply, two adder stages ending in the masks) and the verdict register.
// One item is taken per cycle; a stall on the output holds the pipeline and empty
// stages fill up under it. Distances are exact; zero counts as inside.
module aabb_frustum_plane_test_core #(
    parameter int MAX_PLANES = 8,
    parameter int COORD_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [afpt_pkg::ACTIVE_W-1:0] cfg_wdata,   // active_planes
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // plane_slot, normal_x, normal_y, normal_z, plane_dist,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, zero pad
    input  logic [afpt_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic s_axis_tuser,                          // operation
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // verdict, outside_planes, straddle_planes, zero pad
    output logic [afpt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int NP = MAX_PLANES;
    localparam int CW = COORD_BITS;
    localparam int NW = afpt_pkg::NORMAL_W;
    localparam int PW = CW + NW;
    localparam int SW = CW + NW + 1;
    localparam int FW = afpt_pkg::FIELD_W;

    logic [afpt_pkg::ACTIVE_W-1:0] active_planes_reg;

    logic signed [NW-1:0] plane_n_reg [NP][3];
    logic signed [CW-1:0] plane_d_reg [NP];

    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic en0, en1, en2, en3, out_en;

    logic in_accept;
    afpt_pkg::op_t in_op;
    logic [afpt_pkg::SLOT_W-1:0] in_slot;

    logic signed [CW-1:0] s0_lo_next [3];
    logic signed [CW-1:0] s0_hi_next [3];
    logic signed [CW-1:0] s0_lo_reg [3];
    logic signed [CW-1:0] s0_hi_reg [3];

    logic signed [PW-1:0] s1_pprod_next [NP][3];
    logic signed [PW-1:0] s1_nprod_next [NP][3];
    logic signed [PW-1:0] s1_pprod_reg [NP][3];
    logic signed [PW-1:0] s1_nprod_reg [NP][3];
    logic signed [CW-1:0] s1_d_reg [NP];

    logic signed [SW-1:0] s2_pab_next [NP];
    logic signed [SW-1:0] s2_pc_next [NP];
    logic signed [SW-1:0] s2_nab_next [NP];
    logic signed [SW-1:0] s2_nc_next [NP];
    logic signed [SW-1:0] s2_pab_reg [NP];
    logic signed [SW-1:0] s2_pc_reg [NP];
    logic signed [SW-1:0] s2_nab_reg [NP];
    logic signed [SW-1:0] s2_nc_reg [NP];

    logic [NP-1:0] s3_out_next, s3_str_next;
    logic [NP-1:0] s3_out_reg, s3_str_reg;

    logic [afpt_pkg::OUT_DATA_W-1:0] out_data_next, out_data_reg;

    assign out_en = !out_valid_reg || m_axis_tready;
    assign en3    = !s3_valid_reg || out_en;
    assign en2    = !s2_valid_reg || en3;
    assign en1    = !s1_valid_reg || en2;
    assign en0    = !s0_valid_reg || en1;

    assign s_axis_tready = en0;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign in_accept = s_axis_tvalid && en0;
    assign in_op     = afpt_pkg::op_t'(s_axis_tuser);
    assign in_slot   = s_axis_tdata[afpt_pkg::IN_SLOT_LSB +: afpt_pkg::SLOT_W];

    // coordinates: low COORD_BITS of each field, sign extended
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            s0_lo_next[a] = CW'(s_axis_tdata[afpt_pkg::IN_MIN_LSB + a * FW +: FW]);
            s0_hi_next[a] = CW'(s_axis_tdata[afpt_pkg::IN_MAX_LSB + a * FW +: FW]);
        end
    end

    // stage 1: p/n corner pick and products
    always_comb
    begin
        for (int i = 0; i < NP; i++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (plane_n_reg[i][a][NW-1])
                begin
                    s1_pprod_next[i][a] = PW'(plane_n_reg[i][a]) * PW'(s0_lo_reg[a]);
                    s1_nprod_next[i][a] = PW'(plane_n_reg[i][a]) * PW'(s0_hi_reg[a]);
                end
                else
                begin
                    s1_pprod_next[i][a] = PW'(plane_n_reg[i][a]) * PW'(s0_hi_reg[a]);
                    s1_nprod_next[i][a] = PW'(plane_n_reg[i][a]) * PW'(s0_lo_reg[a]);
                end
            end
        end
    end

    // stage 2: partial sums, distance scaled to the product format
    always_comb
    begin
        for (int i = 0; i < NP; i++)
        begin
            s2_pab_next[i] = SW'(s1_pprod_reg[i][0]) + SW'(s1_pprod_reg[i][1]);
            s2_nab_next[i] = SW'(s1_nprod_reg[i][0]) + SW'(s1_nprod_reg[i][1]);
            s2_pc_next[i]  = SW'(s1_pprod_reg[i][2])
                           - (SW'(s1_d_reg[i]) <<< afpt_pkg::DIST_SHIFT);
            s2_nc_next[i]  = SW'(s1_nprod_reg[i][2])
                           - (SW'(s1_d_reg[i]) <<< afpt_pkg::DIST_SHIFT);
        end
    end

    // stage 3: sign of final distance, inactive planes dropped
    always_comb
    begin
        logic signed [SW-1:0] psum;
        logic signed [SW-1:0] nsum;
        logic                 act;
        for (int i = 0; i < NP; i++)
        begin
            psum = s2_pab_reg[i] + s2_pc_reg[i];
            nsum = s2_nab_reg[i] + s2_nc_reg[i];
            act  = (i < int'(active_planes_reg));
            s3_out_next[i] = act && psum[SW-1];
            s3_str_next[i] = act && nsum[SW-1];
        end
    end

    // output: verdict and 8-bit masks
    always_comb
    begin
        afpt_pkg::verdict_t verdict;
        logic [afpt_pkg::MASK_W-1:0] out_mask;
        logic [afpt_pkg::MASK_W-1:0] str_mask;
        out_mask = '0;
        str_mask = '0;
        for (int b = 0; b < afpt_pkg::MASK_W; b++)
        begin
            if (b < NP)
            begin
                out_mask[b] = s3_out_reg[b];
                str_mask[b] = s3_str_reg[b];
            end
        end
        if (|s3_out_reg)
            verdict = afpt_pkg::VERDICT_OUTSIDE;
        else if (|s3_str_reg)
            verdict = afpt_pkg::VERDICT_STRADDLE;
        else
            verdict = afpt_pkg::VERDICT_INSIDE;
        out_data_next = '0;
        out_data_next[afpt_pkg::OUT_VERDICT_LSB +: 2] = verdict;
        out_data_next[afpt_pkg::OUT_OUTSIDE_LSB +: afpt_pkg::MASK_W] = out_mask;
        out_data_next[afpt_pkg::OUT_STRADDLE_LSB +: afpt_pkg::MASK_W] = str_mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_planes_reg <= afpt_pkg::ACTIVE_W'(afpt_pkg::ACTIVE_RESET);
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NP; i++)
            begin
                plane_d_reg[i] <= '0;
                for (int a = 0; a < 3; a++)
                begin
                    plane_n_reg[i][a] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_we)
                active_planes_reg <= cfg_wdata;
            if (en0)
                s0_valid_reg <= s_axis_tvalid && (in_op == afpt_pkg::OP_TEST);
            if (en1)
                s1_valid_reg <= s0_valid_reg;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
            if (out_en)
                out_valid_reg <= s3_valid_reg;
            // slots at or above MAX_PLANES match no entry and are dropped
            if (in_accept && (in_op == afpt_pkg::OP_LOAD))
            begin
                for (int i = 0; i < NP; i++)
                begin
                    if (int'(in_slot) == i)
                    begin
                        plane_n_reg[i][0] <= s_axis_tdata[afpt_pkg::IN_NX_LSB +: NW];
                        plane_n_reg[i][1] <= s_axis_tdata[afpt_pkg::IN_NY_LSB +: NW];
                        plane_n_reg[i][2] <= s_axis_tdata[afpt_pkg::IN_NZ_LSB +: NW];
                        plane_d_reg[i] <= CW'(s_axis_tdata[afpt_pkg::IN_D_LSB +: FW]);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            s0_lo_reg <= s0_lo_next;
            s0_hi_reg <= s0_hi_next;
        end
        if (en1)
        begin
            s1_pprod_reg <= s1_pprod_next;
            s1_nprod_reg <= s1_nprod_next;
            s1_d_reg     <= plane_d_reg;
        end
        if (en2)
        begin
            s2_pab_reg <= s2_pab_next;
            s2_pc_reg  <= s2_pc_next;
            s2_nab_reg <= s2_nab_next;
            s2_nc_reg  <= s2_nc_next;
        end
        if (en3)
        begin
            s3_out_reg <= s3_out_next;
            s3_str_reg <= s3_str_next;
        end
        if (out_en)
            out_data_reg <= out_data_next;
    end

endmodule
